// ===== src/signed_decimal_to_seven_segment_defines.svh =====
`ifndef SIGNED_DECIMAL_TO_SEVEN_SEGMENT_DEFINES_SVH
`define SIGNED_DECIMAL_TO_SEVEN_SEGMENT_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define SDSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define SDSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sdss_pkg.sv =====
`default_nettype none

package sdss_pkg;

    localparam int DIGITS   = 6;
    localparam int IN_W     = 21;
    localparam int POINT_W  = 3;
    localparam int POS_W    = 3;
    localparam int SEG_W    = 8;
    localparam int LIMIT    = 10**DIGITS - 1;
    localparam int REM_W    = $clog2(LIMIT + 1);
    localparam int CMP_W    = (REM_W > IN_W) ? REM_W : IN_W;
    localparam int IDX_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int STEP_W   = $clog2(DIGITS + 1);
    localparam int PT_CMP_W = POINT_W + 1;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    localparam logic [SEG_W-1:0] MINUS_PATTERN = 8'h40;
    localparam logic [SEG_W-1:0] POINT_BIT     = 8'h80;

    typedef logic [9:0][REM_W-1:0] mult_row_t;
    typedef mult_row_t [DIGITS-1:0] mult_tab_t;

    typedef struct packed {
        logic [REM_W-1:0]   mag;
        logic               negative;
        logic [POINT_W-1:0] point;
        logic               overflow;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // row i holds k * 10^(DIGITS-1-i) for k = 0..9
    function automatic mult_tab_t build_mults();
        mult_tab_t t;
        int        p;
        p = 1;
        for (int i = DIGITS - 1; i >= 0; i--)
        begin
            for (int k = 0; k < 10; k++)
            begin
                t[i][k] = REM_W'(p * k);
            end
            p = p * 10;
        end
        return t;
    endfunction

    localparam mult_tab_t MULTS = build_mults();

    function automatic logic [6:0] digit_segments(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            default: s = 7'h6f;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/sdss_front.sv =====
`default_nettype none

module sdss_front (
    input  wire logic                        push,
    input  wire logic signed [sdss_pkg::IN_W-1:0]    signed_value,
    input  wire logic [sdss_pkg::POINT_W-1:0] point_position,
    input  wire sdss_pkg::q_status_t         q_status,
    output logic                             q_push,
    output sdss_pkg::entry_t                 q_entry
);

    logic                          negative;
    logic [sdss_pkg::IN_W-1:0]     mag;
    logic [sdss_pkg::CMP_W-1:0]    mag_ext;
    logic                          sat;

    always_comb
    begin
        negative = signed_value[sdss_pkg::IN_W-1];
        mag      = negative ? (sdss_pkg::IN_W'(0) - sdss_pkg::IN_W'(signed_value))
                            : sdss_pkg::IN_W'(signed_value);
        mag_ext  = sdss_pkg::CMP_W'(mag);
        sat      = mag_ext > sdss_pkg::CMP_W'(sdss_pkg::LIMIT);

        q_entry.mag      = sat ? sdss_pkg::REM_W'(sdss_pkg::LIMIT)
                               : sdss_pkg::REM_W'(mag_ext);
        q_entry.negative = negative;
        q_entry.point    = point_position;
        q_entry.overflow = sat;
        q_push           = push && !q_status.full;
    end

endmodule

`default_nettype wire

// ===== src/sdss_queue.sv =====
`default_nettype none

module sdss_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_push,
    input  wire sdss_pkg::entry_t  q_entry,
    input  wire logic              q_pop,
    output sdss_pkg::q_status_t    q_status,
    output sdss_pkg::entry_t       q_head
);

    sdss_pkg::entry_t               mem_reg [sdss_pkg::QDEPTH];
    logic [sdss_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [sdss_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [sdss_pkg::QCNT_W-1:0]    count_reg, count_next;

    function automatic logic [sdss_pkg::QPTR_W-1:0] bump(
        input logic [sdss_pkg::QPTR_W-1:0] p);
        logic [sdss_pkg::QPTR_W-1:0] r;
        if (p == sdss_pkg::QPTR_W'(sdss_pkg::QDEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + sdss_pkg::QPTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = q_push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = q_pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (q_push && !q_pop)
        begin
            count_next = count_reg + sdss_pkg::QCNT_W'(1);
        end
        else if (!q_push && q_pop)
        begin
            count_next = count_reg - sdss_pkg::QCNT_W'(1);
        end
        q_status.full  = count_reg == sdss_pkg::QCNT_W'(sdss_pkg::QDEPTH);
        q_status.empty = count_reg == '0;
        q_head         = mem_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            mem_reg[wr_ptr_reg] <= q_entry;
        end
    end

endmodule

`default_nettype wire

// ===== src/sdss_back.sv =====
`default_nettype none

module sdss_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [sdss_pkg::POS_W-1:0]   cfg_wr_data,
    input  wire sdss_pkg::q_status_t          q_status,
    input  wire sdss_pkg::entry_t             q_head,
    output logic                              q_pop,
    input  wire logic                         pop,
    output logic                              empty,
    output logic [sdss_pkg::POS_W-1:0]        position,
    output logic [sdss_pkg::SEG_W-1:0]        segments,
    output logic                              last,
    output logic                              overflow
);

    logic [sdss_pkg::POS_W-1:0]  offset_reg;
    logic [sdss_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        leading_reg, leading_next;
    logic [sdss_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic                        out_valid_reg, out_valid_next;
    logic [sdss_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [sdss_pkg::SEG_W-1:0]  seg_reg, seg_next;
    logic                        last_reg, last_next;
    logic                        ovf_reg, ovf_next;

    logic                          advance;
    logic                          work;
    logic [sdss_pkg::IDX_W-1:0]    idx;
    logic [3:0]                    d;
    logic                          final_digit;
    logic                          has_point;
    logic                          nonblank;

    always_comb
    begin
        advance     = !out_valid_reg || pop;
        work        = advance && !q_status.empty;
        idx         = sdss_pkg::IDX_W'(step_reg - sdss_pkg::STEP_W'(1));
        final_digit = step_reg == sdss_pkg::STEP_W'(sdss_pkg::DIGITS);

        d = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_reg >= sdss_pkg::MULTS[idx][k])
            begin
                d = 4'(k);
            end
        end

        has_point = (q_head.point != '0) &&
                    ({1'b0, q_head.point} ==
                     sdss_pkg::PT_CMP_W'(sdss_pkg::DIGITS) - sdss_pkg::PT_CMP_W'(idx));
        nonblank  = (d != 4'd0) || !leading_reg || final_digit;

        step_next      = step_reg;
        leading_next   = leading_reg;
        rem_next       = rem_reg;
        out_valid_next = advance ? 1'b0 : out_valid_reg;
        pos_next       = pos_reg;
        seg_next       = seg_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        q_pop          = 1'b0;

        if (work)
        begin
            ovf_next  = q_head.overflow;
            last_next = 1'b0;
            if (step_reg == '0)
            begin
                rem_next       = q_head.mag;
                leading_next   = 1'b1;
                step_next      = sdss_pkg::STEP_W'(1);
                out_valid_next = q_head.negative;
                pos_next       = offset_reg;
                seg_next       = sdss_pkg::MINUS_PATTERN;
            end
            else
            begin
                rem_next = rem_reg - sdss_pkg::MULTS[idx][d];
                pos_next = sdss_pkg::POS_W'(idx) + offset_reg;
                if (nonblank)
                begin
                    leading_next   = 1'b0;
                    out_valid_next = 1'b1;
                    seg_next       = {has_point, sdss_pkg::digit_segments(d)};
                end
                else
                begin
                    // keep the minus when the leftmost digit is blank
                    out_valid_next = !((idx == '0) && q_head.negative);
                    seg_next       = has_point ? sdss_pkg::POINT_BIT : '0;
                end
                if (final_digit)
                begin
                    last_next = 1'b1;
                    step_next = '0;
                    q_pop     = 1'b1;
                end
                else
                begin
                    step_next = step_reg + sdss_pkg::STEP_W'(1);
                end
            end
        end

        empty    = !out_valid_reg;
        position = pos_reg;
        segments = seg_reg;
        last     = last_reg;
        overflow = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            step_reg      <= '0;
            leading_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
            step_reg      <= step_next;
            leading_reg   <= leading_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        pos_reg  <= pos_next;
        seg_reg  <= seg_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

endmodule

`default_nettype wire

// ===== src/signed_decimal_to_seven_segment.sv =====
// Channel   Handshake          Fields
// input     push / full        signed_value, point_position
// result    empty / pop        position, segments, last, overflow
// config    cfg_wr_en          cfg_wr_data (position offset)
//
// Each word passes the digit sequencer as one sign step, then one digit per cycle
// while it is not stalled, against a constant power-of-ten table.
// Up to two words wait in the queue between the front and the sequencer.
// Reset clears the queue, the sequencer and the offset register.
// The sequencer stalls only while a result waits on the ports and pop is low.
`default_nettype none

module signed_decimal_to_seven_segment (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    output logic                                      full,
    input  wire logic signed [sdss_pkg::IN_W-1:0]     signed_value,
    input  wire logic [sdss_pkg::POINT_W-1:0]         point_position,
    output logic                                      empty,
    input  wire logic                                 pop,
    output logic [sdss_pkg::POS_W-1:0]                position,
    output logic [sdss_pkg::SEG_W-1:0]                segments,
    output logic                                      last,
    output logic                                      overflow,
    input  wire logic                                 cfg_wr_en,
    input  wire logic [sdss_pkg::POS_W-1:0]           cfg_wr_data
);

    sdss_pkg::q_status_t q_status;
    sdss_pkg::entry_t    q_entry;
    sdss_pkg::entry_t    q_head;
    logic                q_push;
    logic                q_pop;

    sdss_front u_front (
        .push           (push),
        .signed_value   (signed_value),
        .point_position (point_position),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    sdss_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .q_status (q_status),
        .q_head   (q_head)
    );

    sdss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_status    (q_status),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .position    (position),
        .segments    (segments),
        .last        (last),
        .overflow    (overflow)
    );

    assign full = q_status.full;

endmodule

`default_nettype wire

// ===== src/sdss_checker.sv =====
`default_nettype none
`include "signed_decimal_to_seven_segment_defines.svh"

module sdss_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire logic [sdss_pkg::POS_W-1:0]    position,
    input  wire logic [sdss_pkg::SEG_W-1:0]    segments,
    input  wire logic                          last,
    input  wire logic                          overflow
);

    // hold a stalled word
    `SDSS_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(position) && $stable(segments) && $stable(last) && $stable(overflow), "stalled word changed")

    // the final digit is never blank
    `SDSS_ASSERT_NOW(a_last_lit, clk, rst_n, !empty && last, segments[6:0] != 7'h00, "blank final digit")

    // a minus is never last and never carries a point
    `SDSS_ASSERT_NOW(a_minus, clk, rst_n, !empty && segments[6:0] == 7'h40, !last && !segments[7], "bad minus word")

    // a saturated value shows only nines
    `SDSS_ASSERT_NOW(a_sat_nines, clk, rst_n, !empty && overflow && segments[6:0] != 7'h00 && segments[6:0] != 7'h40, segments[6:0] == 7'h6f, "saturated digit not nine")

endmodule

bind signed_decimal_to_seven_segment sdss_checker u_sdss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .position (position),
    .segments (segments),
    .last     (last),
    .overflow (overflow)
);

`default_nettype wire

// ===== tb/sv/sdss_digit_checker.sv =====
`default_nettype none

module sdss_digit_checker
    import sdss_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire logic                      full,
    input  wire logic signed [IN_W-1:0]    signed_value,
    input  wire logic [POINT_W-1:0]        point_position,
    input  wire logic                      empty,
    input  wire logic                      pop,
    input  wire logic [POS_W-1:0]          position,
    input  wire logic [SEG_W-1:0]          segments,
    input  wire logic                      last,
    input  wire logic                      overflow,
    input  wire logic                      cfg_wr_en,
    input  wire logic [POS_W-1:0]          cfg_wr_data,
    output int                             fail_count,
    output int                             pending,
    output int                             word_count,
    output int                             write_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [SEG_W-1:0] seg;
        logic             last;
        logic             ovf;
    } digit_write_t;

    localparam logic [6:0] GLYPH [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
    };

    logic [POS_W-1:0] offset;
    digit_write_t     expected_writes [$];

    function automatic digit_write_t make_write(input int idx, input logic [SEG_W-1:0] seg,
                                                input logic ovf);
        digit_write_t w;
        w.pos  = POS_W'(idx + int'(offset));
        w.seg  = seg;
        w.last = 1'b0;
        w.ovf  = ovf;
        return w;
    endfunction

    function automatic void predict_digits(input logic signed [IN_W-1:0] value,
                                           input logic [POINT_W-1:0] point);
        digit_write_t run [$];
        int           mag;
        int           scale;
        int           limit;
        int           d;
        logic         neg;
        logic         ovf;
        logic         leading;
        logic         dot;
        neg = value[IN_W-1];
        mag = neg ? -int'(value) : int'(value);
        scale = 1;
        for (int i = 1; i < DIGITS; i++)
        begin
            scale *= 10;
        end
        limit = scale * 10 - 1;
        ovf = (mag > limit);
        if (ovf)
        begin
            mag = limit;
        end
        leading = 1'b1;
        if (neg)
        begin
            run.push_back(make_write(0, MINUS_PATTERN, ovf));
        end
        for (int i = 0; i < DIGITS; i++)
        begin
            d = mag / scale;
            mag -= d * scale;
            scale /= 10;
            dot = (point != 0) && (int'(point) == DIGITS - i);
            if (d != 0 || !leading || i == DIGITS - 1)
            begin
                leading = 1'b0;
                run.push_back(make_write(i, {1'b0, GLYPH[d]} | (dot ? POINT_BIT : SEG_W'(0)),
                                         ovf));
            end
            else if (!(i == 0 && neg))
            begin
                run.push_back(make_write(i, dot ? POINT_BIT : SEG_W'(0), ovf));
            end
        end
        run[run.size() - 1].last = 1'b1;
        foreach (run[k])
        begin
            expected_writes.push_back(run[k]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        digit_write_t want;
        if (!rst_n)
        begin
            offset = '0;
            expected_writes.delete();
            pending = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                write_count++;
                if (expected_writes.size() == 0)
                begin
                    $display("%0t: unexpected word pos=%0d seg=%02h last=%0d ovf=%0d",
                             $time, position, segments, last, overflow);
                    fail_count++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (position !== want.pos)
                    begin
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.pos, position);
                        fail_count++;
                    end
                    if (segments !== want.seg)
                    begin
                        $display("%0t: segments expected %02h actual %02h",
                                 $time, want.seg, segments);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, want.last, last);
                        fail_count++;
                    end
                    if (overflow !== want.ovf)
                    begin
                        $display("%0t: overflow expected %0d actual %0d",
                                 $time, want.ovf, overflow);
                        fail_count++;
                    end
                end
            end
            if (push && !full)
            begin
                predict_digits(signed_value, point_position);
                word_count++;
            end
            if (cfg_wr_en)
            begin
                offset = cfg_wr_data;
            end
            pending = expected_writes.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/signed_decimal_to_seven_segment_tb.sv =====
`default_nettype none

module signed_decimal_to_seven_segment_tb;
    import sdss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int HOLD_AFTER    = 80;
    localparam int PHASES        = 5;
    localparam int PHASE_WORDS   = 41;
    localparam int PHASE_OFFSET [PHASES] = '{7, 3, 0, 5, 1};
    localparam int PHASE_GAP    [PHASES] = '{6, 0, 3, 10, 2};

    localparam int DIR_VALUES [24] = '{
        0, 1, -1, 999999, -999999, 1000000, -1000000, 1048575, -1048576, 123456,
        -123456, -5, -5, 100000, -100000, 10, -90, 7, 456789, -3210,
        99999, -99999, 8, -250000
    };
    localparam int DIR_POINTS [24] = '{
        0, 1, 1, 6, 3, 2, 0, 7, 5, 4,
        6, 0, 1, 6, 1, 2, 3, 7, 0, 4,
        5, 6, 1, 2
    };

    typedef enum int {POP_ALWAYS, POP_HALF, POP_MOSTLY, POP_RARE} pop_mode_t;

    logic                      clk;
    logic                      rst_n;
    logic                      push;
    logic                      full;
    logic signed [IN_W-1:0]    signed_value;
    logic [POINT_W-1:0]        point_position;
    logic                      empty;
    logic                      pop;
    logic [POS_W-1:0]          position;
    logic [SEG_W-1:0]          segments;
    logic                      last;
    logic                      overflow;
    logic                      cfg_wr_en;
    logic [POS_W-1:0]          cfg_wr_data;

    int fail_count;
    int pending;
    int word_count;
    int write_count;
    int idle_cycles;
    int settings_count;
    int burst_left;
    int max_gap;
    bit in_taken;

    signed_decimal_to_seven_segment u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .signed_value   (signed_value),
        .point_position (point_position),
        .empty          (empty),
        .pop            (pop),
        .position       (position),
        .segments       (segments),
        .last           (last),
        .overflow       (overflow),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    sdss_digit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .signed_value   (signed_value),
        .point_position (point_position),
        .empty          (empty),
        .pop            (pop),
        .position       (position),
        .segments       (segments),
        .last           (last),
        .overflow       (overflow),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .word_count     (word_count),
        .write_count    (write_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        in_taken <= push && !full;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // drain the block, then write the offset while idle
    task automatic set_offset(input int value);
        push <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= POS_W'(value);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_count++;
    endtask

    task automatic offer_word(input logic signed [IN_W-1:0] value,
                              input logic [POINT_W-1:0] point);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        push           <= 1'b1;
        signed_value   <= value;
        point_position <= point;
        @(negedge clk);
        while (!in_taken)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : receiver
        pop_mode_t mode;
        int        mode_left;
        bit        held_off;
        mode      = POP_ALWAYS;
        mode_left = 0;
        held_off  = 1'b0;
        pop       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && word_count >= HOLD_AFTER)
            begin
                // hold off long enough for the block to back up into its input
                held_off = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = pop_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                end
                mode_left--;
                case (mode)
                    POP_ALWAYS: pop <= 1'b1;
                    POP_HALF:   pop <= 1'($urandom_range(0, 1));
                    POP_MOSTLY: pop <= ($urandom_range(0, 4) != 0);
                    default:    pop <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int                     sel;
        int                     mag;
        logic                   neg;
        logic signed [IN_W-1:0] v;
        rst_n          = 1'b0;
        push           = 1'b0;
        signed_value   = '0;
        point_position = '0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        burst_left     = 0;
        max_gap        = 4;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        set_offset(0);
        foreach (DIR_VALUES[k])
        begin
            offer_word(IN_W'(DIR_VALUES[k]), POINT_W'(DIR_POINTS[k]));
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_offset((ph == PHASES - 1) ? $urandom_range(0, 7) : PHASE_OFFSET[ph]);
            max_gap    = PHASE_GAP[ph];
            burst_left = 0;
            repeat (PHASE_WORDS)
            begin
                sel = $urandom_range(0, 9);
                neg = 1'($urandom_range(0, 1));
                mag = 0;
                v   = IN_W'($urandom());
                case (sel)
                    3, 4: mag = $urandom_range(0, 99);
                    5:    mag = $urandom_range(999990, 1000010);
                    6:    mag = $urandom_range(100000, 999999);
                    7:    mag = $urandom_range(0, 99999);
                    8:
                    begin
                        mag = 1;
                        repeat ($urandom_range(0, 6)) mag *= 10;
                        mag -= $urandom_range(0, 1);
                    end
                    9:    mag = $urandom_range(0, 1) ? 1048576 : 1048575;
                    default: ;
                endcase
                if (sel > 2)
                begin
                    v = neg ? IN_W'(-mag) : IN_W'(mag);
                end
                offer_word(v, POINT_W'($urandom_range(0, 7)));
            end
        end

        push <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);

        $display("Run covered %0d values and %0d digit writes over %0d offset settings,",
                 word_count, write_count, settings_count);
        $display("%s %0d-cycle hold-off.",
                 "including saturation, both minus-sign cases, every point position and a",
                 HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/sdss_pkg.sv
src/sdss_front.sv
src/sdss_queue.sv
src/sdss_back.sv
src/signed_decimal_to_seven_segment.sv
src/sdss_checker.sv
tb/sv/sdss_digit_checker.sv
tb/sv/signed_decimal_to_seven_segment_tb.sv
